>>> rtl/core/exposure_timer_controller_macros.svh
`ifndef EXPOSURE_TIMER_CONTROLLER_MACROS_SVH
`define EXPOSURE_TIMER_CONTROLLER_MACROS_SVH

// same-cycle implication, checked only outside reset
`define ETC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked only outside reset
`define ETC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/etc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package etc_pkg;

  localparam int MIN_W       = 8;
  localparam int SEC_W       = 6;
  localparam int INT_W       = 7;
  localparam int DUTY_W      = 8;
  localparam int LOCKOUT_W   = 16;
  localparam int TPS_W       = 10;
  localparam int CFG_DATA_W  = 16;

  localparam logic [SEC_W-1:0]     SEC_MAX       = SEC_W'(59);
  localparam logic [MIN_W-1:0]     MIN_MAX       = MIN_W'(255);
  localparam logic [INT_W-1:0]     INT_MAX_PCT   = INT_W'(100);
  localparam logic [LOCKOUT_W-1:0] SINCE_MAX     = '1;
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = LOCKOUT_W'(200);
  localparam logic [TPS_W-1:0]     TPS_RESET     = TPS_W'(1000);

  // duty = (pct * 255) / 100 done as (pct * 255) * ceil(2^21 / 100) >> 21
  localparam int SCALED_W   = INT_W + DUTY_W;
  localparam int DUTY_SHIFT = 21;
  localparam logic [SCALED_W-1:0] DUTY_RECIP = SCALED_W'(20972);

  typedef enum logic [1:0] {
    MODE_MENU  = 2'd0,
    MODE_TIME  = 2'd1,
    MODE_INT   = 2'd2,
    MODE_COUNT = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_LOCKOUT = 1'b0,
    CFG_TPS     = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic stop;
    logic start;
    logic enter;
    logic up;
    logic down;
  } btn_t;

  typedef struct packed {
    mode_t            mode;
    logic             cursor;
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;
    logic [INT_W-1:0] intensity;
    logic             fin;
  } step_t;

  typedef struct packed {
    mode_t             mode;
    logic              cursor;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic [INT_W-1:0]  intensity;
    logic [DUTY_W-1:0] duty;
    logic              fin;
  } pay_t;

endpackage

`default_nettype wire

>>> rtl/core/etc_duty.sv
`timescale 1ns / 1ps
`default_nettype none

module etc_duty
  import etc_pkg::*;
(
  input  mode_t             mode,
  input  logic [INT_W-1:0]  intensity,
  output logic [DUTY_W-1:0] duty
);

  logic [SCALED_W-1:0]   scaled;
  logic [2*SCALED_W-1:0] prod;

  // pct * 255 as (pct << 8) - pct
  assign scaled = {intensity, DUTY_W'(0)} - SCALED_W'(intensity);
  assign prod   = scaled * DUTY_RECIP;
  assign duty   = (mode == MODE_COUNT) ? prod[DUTY_SHIFT +: DUTY_W] : '0;

endmodule

`default_nettype wire

>>> rtl/core/etc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module etc_ctrl
  import etc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  btn_t                 btn,
  input  logic [LOCKOUT_W-1:0] lockout_ms,
  input  logic [TPS_W-1:0]     ticks_per_second,
  output step_t                res
);

  mode_t                mode;
  logic                 cursor;
  logic [MIN_W-1:0]     minutes;
  logic [SEC_W-1:0]     seconds;
  logic [INT_W-1:0]     intensity;
  logic [LOCKOUT_W-1:0] since_press;
  logic [TPS_W-1:0]     prescaler;

  mode_t                mode_next;
  logic                 cursor_next;
  logic [MIN_W-1:0]     minutes_next;
  logic [SEC_W-1:0]     seconds_next;
  logic [INT_W-1:0]     intensity_next;
  logic [LOCKOUT_W-1:0] since_press_next;
  logic [TPS_W-1:0]     prescaler_next;
  logic                 fin;

  logic                 ready;
  logic                 taken;
  logic                 time_zero;
  logic [TPS_W-1:0]     tps;
  logic [TPS_W-1:0]     pre_inc;
  logic [MIN_W-1:0]     up_min;
  logic [SEC_W-1:0]     up_sec;
  logic [MIN_W-1:0]     dn_min;
  logic [SEC_W-1:0]     dn_sec;

  assign ready     = since_press > lockout_ms;
  assign time_zero = (minutes == '0) && (seconds == '0);
  assign tps       = (ticks_per_second == '0) ? TPS_W'(1) : ticks_per_second;
  assign pre_inc   = prescaler + TPS_W'(1);

  // one second up / down, saturating at 255:59 and 0:00
  always_comb begin
    up_min = minutes;
    up_sec = seconds;
    if (seconds >= SEC_MAX) begin
      if (minutes < MIN_MAX) begin
        up_sec = '0;
        up_min = minutes + MIN_W'(1);
      end
    end else begin
      up_sec = seconds + SEC_W'(1);
    end
    dn_min = minutes;
    dn_sec = seconds;
    if (seconds == '0) begin
      if (minutes != '0) begin
        dn_sec = SEC_MAX;
        dn_min = minutes - MIN_W'(1);
      end
    end else begin
      dn_sec = seconds - SEC_W'(1);
    end
  end

  always_comb begin
    mode_next      = mode;
    cursor_next    = cursor;
    minutes_next   = minutes;
    seconds_next   = seconds;
    intensity_next = intensity;
    prescaler_next = prescaler;
    fin            = 1'b0;
    taken          = 1'b0;
    if (mode == MODE_COUNT) begin
      if (ready && btn.stop) begin
        taken     = 1'b1;
        mode_next = MODE_MENU;
        fin       = 1'b1;
      end else if (time_zero) begin
        mode_next = MODE_MENU;
        fin       = 1'b1;
      end else if (pre_inc >= tps) begin
        prescaler_next = '0;
        minutes_next   = dn_min;
        seconds_next   = dn_sec;
        if ((dn_min == '0) && (dn_sec == '0)) begin
          mode_next = MODE_MENU;
          fin       = 1'b1;
        end
      end else begin
        prescaler_next = pre_inc;
      end
    end else if (ready) begin
      if (btn.up) begin
        taken = 1'b1;
        case (mode)
          MODE_MENU: cursor_next = 1'b0;
          MODE_TIME: begin
            minutes_next = up_min;
            seconds_next = up_sec;
          end
          default: begin
            if (intensity < INT_MAX_PCT) intensity_next = intensity + INT_W'(1);
          end
        endcase
      end else if (btn.down) begin
        taken = 1'b1;
        case (mode)
          MODE_MENU: cursor_next = 1'b1;
          MODE_TIME: begin
            minutes_next = dn_min;
            seconds_next = dn_sec;
          end
          default: begin
            if (intensity != '0) intensity_next = intensity - INT_W'(1);
          end
        endcase
      end else if (btn.start && (mode == MODE_MENU)) begin
        taken          = 1'b1;
        mode_next      = MODE_COUNT;
        prescaler_next = '0;
      end else if (btn.enter) begin
        taken = 1'b1;
        if (mode == MODE_MENU) begin
          mode_next = cursor ? MODE_INT : MODE_TIME;
        end else begin
          mode_next = MODE_MENU;
        end
      end
    end
    if (taken) begin
      since_press_next = '0;
    end else if (since_press != SINCE_MAX) begin
      since_press_next = since_press + LOCKOUT_W'(1);
    end else begin
      since_press_next = since_press;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_MENU;
      cursor      <= 1'b0;
      minutes     <= '0;
      seconds     <= '0;
      intensity   <= '0;
      since_press <= '0;
      prescaler   <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      cursor      <= cursor_next;
      minutes     <= minutes_next;
      seconds     <= seconds_next;
      intensity   <= intensity_next;
      since_press <= since_press_next;
      prescaler   <= prescaler_next;
    end
  end

  assign res.mode      = mode_next;
  assign res.cursor    = cursor_next;
  assign res.minutes   = minutes_next;
  assign res.seconds   = seconds_next;
  assign res.intensity = intensity_next;
  assign res.fin       = fin;

endmodule

`default_nettype wire

>>> rtl/core/exposure_timer_controller.sv
`timescale 1ns / 1ps
`default_nettype none

`include "exposure_timer_controller_macros.svh"

// Exposure timer controller. Each accepted item is one 1 ms tick with the five
// active-low button levels; it yields exactly one result beat with the state after
// that tick. The block takes one item per clock cycle while item_ready is high: the
// whole tick update is a single pass of next-state logic on the state registers, and
// the result is registered in the output stage, or in the skid entry while the output
// is stalled. A two-entry output register (output stage plus skid) keeps items flowing
// while one result is stalled; item_ready drops only when both entries hold results.
// Configuration writes are always ready and take effect on the next tick.
module exposure_timer_controller
  import etc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  stop_n,
  input  logic                  start_n,
  input  logic                  enter_n,
  input  logic                  up_n,
  input  logic                  down_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [1:0]            mode,
  output logic                  cursor,
  output logic [MIN_W-1:0]      minutes,
  output logic [SEC_W-1:0]      seconds,
  output logic [INT_W-1:0]      intensity_pct,
  output logic [DUTY_W-1:0]     uv_duty,
  output logic                  finished
);

  logic [LOCKOUT_W-1:0] lockout_ms;
  logic [TPS_W-1:0]     ticks_per_second;
  logic                 accept;
  btn_t                 btn;
  step_t                res;
  logic [DUTY_W-1:0]    duty;
  pay_t                 pay;
  pay_t                 out_q;
  pay_t                 skid_q;
  logic                 skid_valid;

  assign cfg_ready  = 1'b1;
  assign item_ready = !skid_valid;
  assign accept     = item_valid && item_ready;

  assign btn.stop  = !stop_n;
  assign btn.start = !start_n;
  assign btn.enter = !enter_n;
  assign btn.up    = !up_n;
  assign btn.down  = !down_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ms       <= LOCKOUT_RESET;
      ticks_per_second <= TPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOCKOUT: lockout_ms       <= cfg_data[LOCKOUT_W-1:0];
        CFG_TPS:     ticks_per_second <= cfg_data[TPS_W-1:0];
        default: ;
      endcase
    end
  end

  etc_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .btn              (btn),
    .lockout_ms       (lockout_ms),
    .ticks_per_second (ticks_per_second),
    .res              (res)
  );

  etc_duty u_duty (
    .mode      (res.mode),
    .intensity (res.intensity),
    .duty      (duty)
  );

  assign pay.mode      = res.mode;
  assign pay.cursor    = res.cursor;
  assign pay.minutes   = res.minutes;
  assign pay.seconds   = res.seconds;
  assign pay.intensity = res.intensity;
  assign pay.duty      = duty;
  assign pay.fin       = res.fin;

  // output stage with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= skid_valid || accept;
      skid_valid   <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      out_q <= skid_valid ? skid_q : pay;
    end else if (accept) begin
      skid_q <= pay;
    end
  end

  assign mode          = out_q.mode;
  assign cursor        = out_q.cursor;
  assign minutes       = out_q.minutes;
  assign seconds       = out_q.seconds;
  assign intensity_pct = out_q.intensity;
  assign uv_duty       = out_q.duty;
  assign finished      = out_q.fin;

  `ETC_ASSERT_NOW(a_skid_needs_out, skid_valid, result_valid, "skid full with output empty")
  `ETC_ASSERT_NOW(a_duty_only_counting, result_valid && (uv_duty != '0), mode == MODE_COUNT, "lamp on outside countdown")
  `ETC_ASSERT_NOW(a_finish_to_menu, result_valid && finished, mode == MODE_MENU, "finish without return to menu")
  `ETC_ASSERT_NEXT(a_stall_blocks_input, result_valid && !result_ready && skid_valid, !accept || result_ready, "item taken with both entries held")

endmodule

`default_nettype wire
